@@ rtl/wmd_pkg.sv @@
`default_nettype none

package wmd_pkg;

  localparam int unsigned WINDOW_SIZE = 16;
  localparam int unsigned SlotW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned PctW = 7;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ActW = 2;

  localparam logic [ActW-1:0] ActTick  = 2'd0;
  localparam logic [ActW-1:0] ActArm   = 2'd1;
  localparam logic [ActW-1:0] ActReset = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgActiveLow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval  = 2'd2;

  localparam logic [PctW-1:0] PctMax = 7'd100;
  localparam logic [PctW-1:0] PctReset = 7'd90;
  localparam logic [IntervalW-1:0] IntervalReset = 32'd1000;
  localparam logic [IntervalW-1:0] IntervalSat = '1;

  typedef logic [CntW-1:0] thr_table_t [2**PctW];

  typedef struct packed {
    logic                 active_low;
    logic [PctW-1:0]      threshold_percent;
    logic [IntervalW-1:0] sample_interval;
  } cfg_t;

  // ceil(size * percent / 100), capped at size, for every 7-bit percent code
  function automatic thr_table_t build_thr_table();
    thr_table_t tbl;
    int unsigned v;
    for (int unsigned i = 0; i < 2**PctW; i++) begin
      v = (WINDOW_SIZE * i + 99) / 100;
      tbl[i] = (v > WINDOW_SIZE) ? CntW'(WINDOW_SIZE) : CntW'(v);
    end
    return tbl;
  endfunction

  localparam thr_table_t ThrTable = build_thr_table();

endpackage

`default_nettype wire

@@ rtl/wmd_cfg.sv @@
`default_nettype none

module wmd_cfg
  import wmd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output      cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [PctW-1:0] pct;

  assign cfg_ready_o = 1'b1;
  assign pct = cfg_data_i[PctW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgActiveLow: cfg_d.active_low = cfg_data_i[0];
        CfgThreshold: begin
          if (pct <= PctMax) cfg_d.threshold_percent = pct;
        end
        CfgInterval: cfg_d.sample_interval = cfg_data_i[IntervalW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low        <= 1'b0;
      cfg_q.threshold_percent <= PctReset;
      cfg_q.sample_interval   <= IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/wmd_core.sv @@
`default_nettype none

module wmd_core
  import wmd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic [ActW-1:0] action_i,
  input  wire logic            raw_level_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      logic            stable_state_o,
  output      logic            pressed_event_o,
  output      logic            released_event_o,
  output      logic            armed_o
);

  // input register
  logic            in_valid_q, in_valid_d;
  logic [ActW-1:0] action_q;
  logic            level_q;

  // debounce state
  logic [WINDOW_SIZE-1:0] window_q, window_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   active_q, active_d;
  logic                   pressed_q, pressed_d;
  logic [IntervalW-1:0]   ticks_q, ticks_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic res_stable_q, res_press_q, res_release_q, res_armed_q;
  logic press_ev, release_ev;

  logic            out_free;
  logic            process;
  logic            sample_bit;
  logic [CntW-1:0] thr;
  logic [CntW:0]   rel_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_valid_d = (in_valid_i && !in_stall_o) || (in_valid_q && !process);
  assign out_valid_d = process || (out_valid_q && out_stall_i);

  assign thr        = ThrTable[cfg_i.threshold_percent];
  assign sample_bit = level_q ^ cfg_i.active_low;

  always_comb begin
    window_d   = window_q;
    slot_d     = slot_q;
    count_d    = count_q;
    active_d   = active_q;
    pressed_d  = pressed_q;
    ticks_d    = ticks_q;
    press_ev   = 1'b0;
    release_ev = 1'b0;
    rel_sum    = '0;
    if (process) begin
      case (action_q)
        ActReset: begin
          window_d  = '0;
          slot_d    = '0;
          count_d   = '0;
          active_d  = 1'b0;
          pressed_d = 1'b0;
          ticks_d   = '0;
        end
        ActArm: begin
          if (!active_q && !pressed_q) begin
            active_d = 1'b1;
            window_d = '0;
            slot_d   = '0;
            count_d  = '0;
            ticks_d  = '0;
          end
        end
        ActTick: begin
          if (active_q) begin
            if (ticks_q != IntervalSat) ticks_d = ticks_q + 1'b1;
            if (ticks_d >= cfg_i.sample_interval) begin
              ticks_d = '0;
              count_d = count_q - CntW'(window_q[slot_q]) + CntW'(sample_bit);
              window_d[slot_q] = sample_bit;
              slot_d = (slot_q == SlotW'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
              rel_sum = {1'b0, count_d} + {1'b0, thr};
              if (!pressed_q) begin
                if (count_d >= thr) begin
                  pressed_d = 1'b1;
                  press_ev  = 1'b1;
                end
              end else if (rel_sum <= (CntW+1)'(WINDOW_SIZE)) begin
                pressed_d  = 1'b0;
                release_ev = 1'b1;
                active_d   = 1'b0;
                window_d   = '0;
                slot_d     = '0;
                count_d    = '0;
              end
            end
          end
        end
        default: begin
          window_d = window_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      pressed_q   <= 1'b0;
      ticks_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      window_q    <= window_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      active_q    <= active_d;
      pressed_q   <= pressed_d;
      ticks_q     <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_i;
      level_q  <= raw_level_i;
    end
    if (process) begin
      res_stable_q  <= pressed_d;
      res_press_q   <= press_ev;
      res_release_q <= release_ev;
      res_armed_q   <= active_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stable_state_o   = res_stable_q;
  assign pressed_event_o  = res_press_q;
  assign released_event_o = res_release_q;
  assign armed_o          = res_armed_q;

endmodule

`default_nettype wire

@@ rtl/window_majority_debouncer.sv @@
// Sliding-window majority debouncer for one push button.
// Input channel (in_valid_i / in_stall_o): action_i selects a tick carrying
// raw_level_i, an arm on a falling pin edge, or a full state clear.
// Output channel (out_valid_o / out_stall_i): one result item per input
// item with the debounced state, press and release pulses and the armed flag.
// Configuration channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects
// 0 active_low, 1 threshold_percent, 2 sample_interval; always ready. The
// user must write it only while no item is in flight; the block does not enforce it.
// Path: an accepted item is held in the input register, is worked on once the
// result register is free or being taken, and then lands in the result
// register, from where the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single update of the window, count and tick counter between input and result register.
// Reset clears the window, counters, session and pressed state, and the
// registers return to active high, 90 percent and 1000 ticks.
// When the receiver stalls the result holds; the input register keeps one
// further item and in_stall_o rises only once that register is also full.
`default_nettype none

module window_majority_debouncer
  import wmd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [ActW-1:0]     action_i,
  input  wire logic                raw_level_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                stable_state_o,
  output      logic                pressed_event_o,
  output      logic                released_event_o,
  output      logic                armed_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;

  wmd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wmd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .raw_level_i      (raw_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .stable_state_o   (stable_state_o),
    .pressed_event_o  (pressed_event_o),
    .released_event_o (released_event_o),
    .armed_o          (armed_o)
  );

endmodule

`default_nettype wire

@@ rtl/wmd_checker.sv @@
`default_nettype none

module wmd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic stable_state_o,
  input wire logic pressed_event_o,
  input wire logic released_event_o,
  input wire logic armed_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o
      && $stable(stable_state_o) && $stable(pressed_event_o)
      && $stable(released_event_o) && $stable(armed_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pressed_event_o && released_event_o))
    else $error("press and release on one item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressed_event_o |-> stable_state_o && armed_o)
    else $error("press without pressed session");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && released_event_o |-> !stable_state_o && !armed_o)
    else $error("release left session running");

  // pressed only inside a session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stable_state_o |-> armed_o)
    else $error("pressed while disarmed");

endmodule

bind window_majority_debouncer wmd_checker u_wmd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .stable_state_o   (stable_state_o),
  .pressed_event_o  (pressed_event_o),
  .released_event_o (released_event_o),
  .armed_o          (armed_o)
);

`default_nettype wire
